// File: hdl/interval_merge_and_pad_defines.svh
`ifndef INTERVAL_MERGE_AND_PAD_DEFINES_SVH
`define INTERVAL_MERGE_AND_PAD_DEFINES_SVH

// Checks on the same clock edge.
`define IMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequent in the next cycle.
`define IMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/imp_pkg.sv
`timescale 1ns / 1ps

package imp_pkg;

  localparam int FRAME_BITS_DEF = 24;
  localparam int Q_DEPTH        = 4;
  localparam int CFG_IDX_BITS   = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GAP_LIMIT    = 2'd0,
    REG_PRE_PAD      = 2'd1,
    REG_POST_PAD     = 2'd2,
    REG_VIDEO_LENGTH = 2'd3
  } cfg_idx_t;

  // Front to queue: how many entries go in this cycle.
  typedef struct packed {
    logic push0;
    logic push1;
  } q_wr_t;

endpackage

// File: hdl/interval_merge_and_pad.sv
// Merges a start-sorted stream of frame intervals and pads each merged result.
// Input channel: drive in_seg_start, in_seg_end, in_is_final with in_push high;
// the item transfers at an edge where in_full is low. in_is_final closes a list
// and flushes the held interval (out_last = 1 on that result).
// Result channel: while out_empty is low the oldest result sits on out_start,
// out_end, out_last; it transfers at an edge where out_pop is high.
// Configuration: cfg_we, cfg_addr, cfg_wdata write gap_limit (0), pre_pad (1),
// post_pad (2), video_length (3); write only while the block is idle.
// Throughput: one input item per cycle while the four-entry queue between the
// merge stage and the pad stage has room for two entries; results leave at one
// per cycle while out_pop is high (the pad stage has a single output register).
// Path: a result caused by an item is written to the queue at the edge that
// takes the item in, then moves to the output register once it can take it.
// Reset (rst_n low at an edge): the queue empties, nothing is held, the config
// registers return to zero except video_length, which returns to all ones.
// When the receiver stalls, results pile up in the queue and in_full rises
// once fewer than two entries are free; no result is lost or repeated.
`timescale 1ns / 1ps
`include "interval_merge_and_pad_defines.svh"

module interval_merge_and_pad #(
  parameter int FRAME_BITS = imp_pkg::FRAME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [FRAME_BITS-1:0]            in_seg_start,
  input  logic [FRAME_BITS-1:0]            in_seg_end,
  input  logic                             in_is_final,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [FRAME_BITS-1:0]            out_start,
  output logic [FRAME_BITS-1:0]            out_end,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [imp_pkg::CFG_IDX_BITS-1:0] cfg_addr,
  input  logic [FRAME_BITS-1:0]            cfg_wdata
);

  logic [FRAME_BITS-1:0] gap_limit_r, gap_limit_nxt;
  logic [FRAME_BITS-1:0] pre_pad_r, pre_pad_nxt;
  logic [FRAME_BITS-1:0] post_pad_r, post_pad_nxt;
  logic [FRAME_BITS-1:0] video_length_r, video_length_nxt;

  imp_pkg::q_wr_t        q_wr;
  logic [2*FRAME_BITS:0] q_wdata0;
  logic [2*FRAME_BITS:0] q_wdata1;
  logic [2*FRAME_BITS:0] q_rdata;
  logic                  q_room;
  logic                  q_not_empty;
  logic                  q_rd;
  logic                  in_acc;

  assign in_acc  = in_push && q_room;
  assign in_full = !q_room;

  always_comb begin
    gap_limit_nxt    = gap_limit_r;
    pre_pad_nxt      = pre_pad_r;
    post_pad_nxt     = post_pad_r;
    video_length_nxt = video_length_r;
    if (cfg_we) begin
      case (imp_pkg::cfg_idx_t'(cfg_addr))
        imp_pkg::REG_GAP_LIMIT:    gap_limit_nxt    = cfg_wdata;
        imp_pkg::REG_PRE_PAD:      pre_pad_nxt      = cfg_wdata;
        imp_pkg::REG_POST_PAD:     post_pad_nxt     = cfg_wdata;
        imp_pkg::REG_VIDEO_LENGTH: video_length_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r    <= '0;
      pre_pad_r      <= '0;
      post_pad_r     <= '0;
      video_length_r <= '1;
    end else begin
      gap_limit_r    <= gap_limit_nxt;
      pre_pad_r      <= pre_pad_nxt;
      post_pad_r     <= post_pad_nxt;
      video_length_r <= video_length_nxt;
    end
  end

  imp_front #(
    .FRAME_BITS(FRAME_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .seg_start (in_seg_start),
    .seg_end   (in_seg_end),
    .is_final  (in_is_final),
    .gap_limit (gap_limit_r),
    .wr        (q_wr),
    .wr_data0  (q_wdata0),
    .wr_data1  (q_wdata1)
  );

  imp_queue #(
    .FRAME_BITS(FRAME_BITS),
    .DEPTH     (imp_pkg::Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (q_wr),
    .wr_data0  (q_wdata0),
    .wr_data1  (q_wdata1),
    .room      (q_room),
    .not_empty (q_not_empty),
    .rd        (q_rd),
    .rd_data   (q_rdata)
  );

  imp_back #(
    .FRAME_BITS(FRAME_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .q_data       (q_rdata),
    .q_rd         (q_rd),
    .pre_pad      (pre_pad_r),
    .post_pad     (post_pad_r),
    .video_length (video_length_r),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_start    (out_start),
    .out_end      (out_end),
    .out_last     (out_last)
  );

  // A flush always leaves at least one entry waiting in the queue.
  `IMP_ASSERT_NEXT(a_flush_queued, in_acc && in_is_final, q_not_empty, "flush lost")
  // Draining the last result with nothing queued must empty the output.
  `IMP_ASSERT_NEXT(a_drain_empty, !out_empty && out_pop && !q_not_empty, out_empty,
                   "stale result")
  // The queue only reads what it holds.
  `IMP_ASSERT_NOW(a_rd_nonempty, q_rd, q_not_empty, "read from empty queue")

endmodule

// File: hdl/imp_front.sv
`timescale 1ns / 1ps

module imp_front #(
  parameter int FRAME_BITS = imp_pkg::FRAME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  logic [FRAME_BITS-1:0]   seg_start,
  input  logic [FRAME_BITS-1:0]   seg_end,
  input  logic                    is_final,
  input  logic [FRAME_BITS-1:0]   gap_limit,
  output imp_pkg::q_wr_t          wr,
  output logic [2*FRAME_BITS:0]   wr_data0,
  output logic [2*FRAME_BITS:0]   wr_data1
);

  logic                  held_valid_r, held_valid_nxt;
  logic [FRAME_BITS-1:0] held_start_r, held_start_nxt;
  logic [FRAME_BITS-1:0] held_end_r, held_end_nxt;
  logic [FRAME_BITS:0]   reach;
  logic                  merge;
  logic                  emit0;
  logic [FRAME_BITS-1:0] new_start;
  logic [2*FRAME_BITS:0] held_entry;
  logic [2*FRAME_BITS:0] flush_entry;

  assign reach     = {1'b0, held_end_r} + {1'b0, gap_limit};
  assign merge     = held_valid_r && ({1'b0, seg_start} <= reach);
  assign emit0     = held_valid_r && !merge;
  assign new_start = merge ? held_start_r : seg_start;

  assign held_entry  = {1'b0, held_end_r, held_start_r};
  assign flush_entry = {1'b1, seg_end, new_start};

  // Compact: the sent-out held interval goes first, the flush after it.
  assign wr.push0 = acc && (emit0 || is_final);
  assign wr.push1 = acc && emit0 && is_final;
  assign wr_data0 = emit0 ? held_entry : flush_entry;
  assign wr_data1 = flush_entry;

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_start_nxt = held_start_r;
    held_end_nxt   = held_end_r;
    if (acc) begin
      if (is_final) begin
        held_valid_nxt = 1'b0;
        held_start_nxt = '0;
        held_end_nxt   = '0;
      end else begin
        held_valid_nxt = 1'b1;
        held_start_nxt = new_start;
        held_end_nxt   = seg_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_start_r <= '0;
      held_end_r   <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_start_r <= held_start_nxt;
      held_end_r   <= held_end_nxt;
    end
  end

endmodule

// File: hdl/imp_queue.sv
`timescale 1ns / 1ps

module imp_queue #(
  parameter int FRAME_BITS = imp_pkg::FRAME_BITS_DEF,
  parameter int DEPTH      = imp_pkg::Q_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  imp_pkg::q_wr_t        wr,
  input  logic [2*FRAME_BITS:0] wr_data0,
  input  logic [2*FRAME_BITS:0] wr_data1,
  output logic                  room,
  output logic                  not_empty,
  input  logic                  rd,
  output logic [2*FRAME_BITS:0] rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [2*FRAME_BITS:0] mem [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] wptr_p1;
  logic          rd_ok;

  assign wptr_p1   = AW'(wptr_r + 1'b1);
  assign not_empty = (count_r != '0);
  assign room      = (count_r <= CW'(DEPTH - 2));
  assign rd_ok     = rd && not_empty;
  assign rd_data   = mem[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (wr.push0 && wr.push1) begin
      wptr_nxt  = AW'(wptr_r + 2'd2);
      count_nxt = CW'(count_nxt + 2'd2);
    end else if (wr.push0) begin
      wptr_nxt  = wptr_p1;
      count_nxt = CW'(count_nxt + 1'b1);
    end
    if (rd_ok) begin
      rptr_nxt  = AW'(rptr_r + 1'b1);
      count_nxt = CW'(count_nxt - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push0) begin
      mem[wptr_r] <= wr_data0;
    end
    if (wr.push1) begin
      mem[wptr_p1] <= wr_data1;
    end
  end

endmodule

// File: hdl/imp_back.sv
`timescale 1ns / 1ps

module imp_back #(
  parameter int FRAME_BITS = imp_pkg::FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  logic [2*FRAME_BITS:0] q_data,
  output logic                  q_rd,
  input  logic [FRAME_BITS-1:0] pre_pad,
  input  logic [FRAME_BITS-1:0] post_pad,
  input  logic [FRAME_BITS-1:0] video_length,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [FRAME_BITS-1:0] out_start,
  output logic [FRAME_BITS-1:0] out_end,
  output logic                  out_last
);

  logic                  valid_r, valid_nxt;
  logic [FRAME_BITS-1:0] start_r, start_nxt;
  logic [FRAME_BITS-1:0] end_r, end_nxt;
  logic                  last_r, last_nxt;
  logic [FRAME_BITS-1:0] q_start;
  logic [FRAME_BITS-1:0] q_end;
  logic [FRAME_BITS:0]   end_sum;
  logic                  take;

  assign q_start = q_data[FRAME_BITS-1:0];
  assign q_end   = q_data[2*FRAME_BITS-1:FRAME_BITS];
  assign end_sum = {1'b0, q_end} + {1'b0, post_pad};

  // Load the output register when it is free or being drained this cycle.
  assign take = q_not_empty && (!valid_r || out_pop);
  assign q_rd = take;

  always_comb begin
    valid_nxt = valid_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    last_nxt  = last_r;
    if (take) begin
      valid_nxt = 1'b1;
      start_nxt = (q_start >= pre_pad) ? FRAME_BITS'(q_start - pre_pad) : '0;
      end_nxt   = (end_sum > {1'b0, video_length}) ? video_length
                                                   : end_sum[FRAME_BITS-1:0];
      last_nxt  = q_data[2*FRAME_BITS];
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    end_r   <= end_nxt;
    last_r  <= last_nxt;
  end

  assign out_empty = !valid_r;
  assign out_start = start_r;
  assign out_end   = end_r;
  assign out_last  = last_r;

endmodule
